FILE: hdl/tat1_pkg.sv
// package for the two-angle t1 map pixel block
// types, constants and helper sizes shared by the cell chain and the top level
// no dependencies
package tat1_pkg;
   localparam int SAMPLE_BITS = 16;
   localparam int LOG_FRAC    = 24;
   localparam int MANT_BITS   = 32;              // Q1.30 mantissa plus headroom bit
   localparam int PROD_BITS   = SAMPLE_BITS + 17; // signed product width
   localparam int V_BITS      = PROD_BITS + 1;   // signed difference width
   localparam int MAG_BITS    = V_BITS - 1;      // magnitude width
   localparam int EXP_BITS    = 6;
   localparam int LOG_BITS    = EXP_BITS + LOG_FRAC;
   localparam int LN_BITS     = LOG_BITS;
   localparam int P_BITS      = LN_BITS + 26;
   localparam int Q_BITS      = 24;              // quotient bits kept, enough above T1_MAX
   localparam int T1_BITS     = 23;
   localparam int DIV_CELLS   = 57;              // one cell per bit of the 2^56 numerator
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [T1_BITS-1:0] T1_MAX = 23'd6553600;

   typedef enum logic [2:0] {
      REG_THRESHOLD = 3'd0,
      REG_K1        = 3'd1,
      REG_K2        = 3'd2,
      REG_K3        = 3'd3,
      REG_K4        = 3'd4,
      REG_INV_TR    = 3'd5
   } reg_index_type;

   // one log cell stage: the two mantissas and their log results, refined in parallel
   typedef struct packed {
      logic                  valid;
      logic                  mapped;
      logic                  ratio_ok;
      logic [SAMPLE_BITS-1:0] s0;
      logic [MANT_BITS-1:0]  ma;
      logic [MANT_BITS-1:0]  mb;
      logic [LOG_BITS-1:0]   la;
      logic [LOG_BITS-1:0]   lb;
   } log_cell_type;

   // one divider cell stage: restoring division, one quotient bit per cell
   typedef struct packed {
      logic                   valid;
      logic                   mapped;
      logic                   do_div;
      logic [SAMPLE_BITS-1:0] s0;
      logic [P_BITS:0]        rem;
      logic [P_BITS-1:0]      divisor;
      logic [Q_BITS-1:0]      quo;
      logic                   ovf;
   } div_cell_type;
endpackage

FILE: hdl/two_angle_t1_map_pixel_top.sv
// top level of the two-angle t1 map pixel block: front stages, log and divider cell chains
// depends on tat1_pkg, tat1_log_cell, tat1_div_cell
//
// channel   dir  handshake            payload
// req       in   req_tvalid/tready    tdata: sample_one[15:0], sample_two[31:16]
// rsp       out  rsp_tvalid/tready    tdata: t1_value[22:0], s0_value[38:23]; tuser: above_noise
// csr       in   csr_valid/ready      csr_index[2:0], csr_data[25:0]
//
// one request per cycle while the response is not stalled; 88 pipeline registers from request to response:
// products, differences, log normalize, 24 log cells, ln scale, rate multiply,
// r1 test, 57 divider cells, saturate into the output register.
// the whole pipeline advances only when the output register is free or being emptied,
// so a stalled response holds every stage. reset is synchronous and clears valid bits,
// the threshold and k registers, and sets the inv_tr register to 65536.
module two_angle_t1_map_pixel_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_one, sample_two
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // t1_value, s0_value, zero fill
   output logic        rsp_tuser,   // above_noise
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [25:0] csr_data
);
   import tat1_pkg::*;

   logic [15:0] thr_ff, k1_ff, k2_ff, k3_ff, k4_ff;
   logic [25:0] itr_ff;
   logic adv;

   assign csr_ready = 1'b1;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0; k1_ff <= '0; k2_ff <= '0; k3_ff <= '0; k4_ff <= '0;
         itr_ff <= 26'd65536;
      end else if (csr_valid) begin
         case (csr_index)
            REG_THRESHOLD: thr_ff <= csr_data[15:0];
            REG_K1:        k1_ff  <= csr_data[15:0];
            REG_K2:        k2_ff  <= csr_data[15:0];
            REG_K3:        k3_ff  <= csr_data[15:0];
            REG_K4:        k4_ff  <= csr_data[15:0];
            REG_INV_TR:    itr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage a: four products
   logic a_valid_ff, a_map_ff;
   logic [SAMPLE_BITS-1:0] a_s0_ff;
   logic signed [PROD_BITS-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic [SAMPLE_BITS-1:0] s1, s2;
   assign s1 = req_tdata[15:0];
   assign s2 = req_tdata[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         a_map_ff <= s1 > thr_ff;
         a_s0_ff  <= s1;
         p1_ff <= $signed({1'b0, s1}) * $signed(k1_ff);
         p2_ff <= $signed({1'b0, s2}) * $signed(k2_ff);
         p3_ff <= $signed({1'b0, s1}) * $signed(k3_ff);
         p4_ff <= $signed({1'b0, s2}) * $signed(k4_ff);
      end
   end

   // stage b: differences and magnitudes
   logic b_valid_ff, b_map_ff, b_ok_ff;
   logic [SAMPLE_BITS-1:0] b_s0_ff;
   logic [MAG_BITS-1:0] ma_ff, mb_ff;
   logic signed [V_BITS-1:0] v1, v2;
   logic [V_BITS-1:0] av1, av2;
   assign v1 = V_BITS'(p1_ff) - V_BITS'(p2_ff);
   assign v2 = V_BITS'(p3_ff) - V_BITS'(p4_ff);
   assign av1 = v1[V_BITS-1] ? -v1 : v1;
   assign av2 = v2[V_BITS-1] ? -v2 : v2;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_map_ff <= a_map_ff;
         b_s0_ff  <= a_s0_ff;
         b_ok_ff  <= (v1 != 0) && (v2 != 0) && (v1[V_BITS-1] == v2[V_BITS-1]);
         ma_ff <= av1[MAG_BITS-1:0];
         mb_ff <= av2[MAG_BITS-1:0];
      end
   end

   // stage c: leading-one normalize into Q1.30
   function automatic logic [EXP_BITS-1:0] msb_pos(input logic [MAG_BITS-1:0] x);
      logic [EXP_BITS-1:0] p;
      p = '0;
      for (int i = 0; i < MAG_BITS; i++) begin
         if (x[i]) p = EXP_BITS'(i);
      end
      return p;
   endfunction

   // leading one lands on bit 30, low bits truncated
   function automatic logic [MANT_BITS-1:0] norm(input logic [MAG_BITS-1:0] x,
                                                 input logic [EXP_BITS-1:0] e);
      logic [MAG_BITS+29:0] w;
      w = {x, 30'd0} >> e;
      return w[MANT_BITS-1:0];
   endfunction

   log_cell_type chain [0:LOG_FRAC];
   logic [EXP_BITS-1:0] ea, eb;
   assign ea = msb_pos(ma_ff);
   assign eb = msb_pos(mb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0].valid <= 1'b0;
      end else if (adv) begin
         chain[0].valid    <= b_valid_ff;
         chain[0].mapped   <= b_map_ff;
         chain[0].ratio_ok <= b_ok_ff;
         chain[0].s0       <= b_s0_ff;
         chain[0].ma       <= norm(ma_ff, ea);
         chain[0].mb       <= norm(mb_ff, eb);
         chain[0].la       <= {ea, {LOG_FRAC{1'b0}}};
         chain[0].lb       <= {eb, {LOG_FRAC{1'b0}}};
      end
   end

   for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
      tat1_log_cell u_cell (
         .clock(clock), .reset(reset), .enable(adv),
         .bit_pos(5'(LOG_FRAC - 1 - g)),
         .cell_in(chain[g]), .cell_out(chain[g+1])
      );
   end

   // stage d: difference times ln2
   logic d_valid_ff, d_map_ff, d_pos_ff;
   logic [SAMPLE_BITS-1:0] d_s0_ff;
   logic [LOG_BITS+29:0] d_prod_ff;
   logic [LOG_BITS-1:0] ldiff;
   assign ldiff = chain[LOG_FRAC].la - chain[LOG_FRAC].lb;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= chain[LOG_FRAC].valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d_map_ff  <= chain[LOG_FRAC].mapped;
         d_s0_ff   <= chain[LOG_FRAC].s0;
         d_pos_ff  <= chain[LOG_FRAC].ratio_ok && (chain[LOG_FRAC].la > chain[LOG_FRAC].lb);
         d_prod_ff <= ldiff * LN2_Q30;
      end
   end

   // stage e: rate multiply
   logic e_valid_ff, e_map_ff, e_pos_ff;
   logic [SAMPLE_BITS-1:0] e_s0_ff;
   logic [P_BITS-1:0] e_p_ff;
   logic [LN_BITS-1:0] lnv;
   assign lnv = d_prod_ff[LOG_BITS+29:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= d_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         e_map_ff <= d_map_ff;
         e_s0_ff  <= d_s0_ff;
         e_pos_ff <= d_pos_ff;
         e_p_ff   <= lnv * itr_ff;
      end
   end

   // stage f: r1 > 0.01 test, start of divider chain
   div_cell_type dchain [0:DIV_CELLS];
   logic [P_BITS+7:0] p100;
   assign p100 = e_p_ff * 8'd100;

   always_ff @(posedge clock) begin
      if (reset) begin
         dchain[0].valid <= 1'b0;
      end else if (adv) begin
         dchain[0].valid   <= e_valid_ff;
         dchain[0].mapped  <= e_map_ff;
         dchain[0].s0      <= e_s0_ff;
         dchain[0].do_div  <= e_pos_ff && (p100 > (P_BITS+8)'(64'd1 << 40));
         dchain[0].rem     <= '0;
         dchain[0].divisor <= e_p_ff;
         dchain[0].quo     <= '0;
         dchain[0].ovf     <= 1'b0;
      end
   end

   // numerator 2^56: only the leading bit is one
   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      tat1_div_cell u_cell (
         .clock(clock), .reset(reset), .enable(adv),
         .num_bit(g == 0),
         .cell_in(dchain[g]), .cell_out(dchain[g+1])
      );
   end

   // output register with saturation
   logic [T1_BITS-1:0] t1_sat;
   div_cell_type dl;
   assign dl = dchain[DIV_CELLS];
   always_comb begin
      if (!dl.mapped || !dl.do_div) begin
         t1_sat = '0;
      end else if (dl.ovf || dl.quo > Q_BITS'(T1_MAX)) begin
         t1_sat = T1_MAX;
      end else begin
         t1_sat = dl.quo[T1_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (adv) begin
         rsp_tvalid <= dl.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata <= {1'b0, dl.mapped ? dl.s0 : 16'd0, t1_sat};
         rsp_tuser <= dl.mapped;
      end
   end
endmodule

FILE: hdl/tat1_log_cell.sv
// one log2 refinement cell: squares both mantissas, emits one result bit each
// depends on tat1_pkg
module tat1_log_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic [4:0]            bit_pos,
   input  tat1_pkg::log_cell_type cell_in,
   output tat1_pkg::log_cell_type cell_out
);
   import tat1_pkg::*;
   log_cell_type cell_ff, cell_in_c;
   logic [2*MANT_BITS-1:0] sqa, sqb;
   logic [MANT_BITS-1:0] na, nb;

   always_comb begin
      sqa = cell_in.ma * cell_in.ma;
      sqb = cell_in.mb * cell_in.mb;
      na = sqa[MANT_BITS+29:30];
      nb = sqb[MANT_BITS+29:30];
      cell_in_c = cell_in;
      if (na[31]) begin
         cell_in_c.ma = na >> 1;
         cell_in_c.la[bit_pos] = 1'b1;
      end else begin
         cell_in_c.ma = na;
      end
      if (nb[31]) begin
         cell_in_c.mb = nb >> 1;
         cell_in_c.lb[bit_pos] = 1'b1;
      end else begin
         cell_in_c.mb = nb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in_c;
      end
   end
   assign cell_out = cell_ff;
endmodule

FILE: hdl/tat1_div_cell.sv
// one restoring-division cell: produces one quotient bit of 2^56 / p
// depends on tat1_pkg
module tat1_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  num_bit,
   input  tat1_pkg::div_cell_type cell_in,
   output tat1_pkg::div_cell_type cell_out
);
   import tat1_pkg::*;
   div_cell_type cell_ff, cell_in_c;
   logic [P_BITS+1:0] shifted;
   logic [P_BITS+1:0] diff;

   always_comb begin
      cell_in_c = cell_in;
      shifted = {cell_in.rem, num_bit};
      diff = shifted - {2'b00, cell_in.divisor};
      cell_in_c.ovf = cell_in.ovf | cell_in.quo[Q_BITS-1];
      if (!diff[P_BITS+1]) begin
         cell_in_c.rem = diff[P_BITS:0];
         cell_in_c.quo = {cell_in.quo[Q_BITS-2:0], 1'b1};
      end else begin
         cell_in_c.rem = shifted[P_BITS:0];
         cell_in_c.quo = {cell_in.quo[Q_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in_c;
      end
   end
   assign cell_out = cell_ff;
endmodule
